>>> design/tce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants for the threshold cross erosion block
// Register indexes, field widths, register reset values and the result beat.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int THRESHOLD_W = 16;   // wall_threshold register
  localparam int LEN_CFG_W   = 11;   // line_length and line_count registers
  localparam int COORD_W     = 10;   // out_line and out_pos
  localparam int CFG_DATA_W  = 16;   // widest register
  localparam int CFG_INDEX_W = 2;

  // floor(0.15 * 65536)
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd9830;
  localparam logic [LEN_CFG_W-1:0]   LENGTH_RESET    = 11'd1024;
  localparam logic [LEN_CFG_W-1:0]   COUNT_RESET     = 11'd1024;
  localparam logic [LEN_CFG_W-1:0]   LEN_MIN         = 11'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WALL_THRESHOLD = 2'd0,
    REG_LINE_LENGTH    = 2'd1,
    REG_LINE_COUNT     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               wall;
    logic [COORD_W-1:0] out_line;
    logic [COORD_W-1:0] out_pos;
    logic               last_of_run;
  } result_t;

  // result queue
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = 3;
  localparam int RES_CNT_W = 4;

endpackage : tce_pkg
`default_nettype wire

>>> design/tce_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tce_sample_if: input channel, one random sample per cell
// valid/ready handshake; a beat moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface tce_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] random_sample;
  logic                   map_start;

  modport source (output valid, output random_sample, output map_start, input ready);
  modport sink   (input valid, input random_sample, input map_start, output ready);
endinterface : tce_sample_if
`default_nettype wire

>>> design/tce_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tce_result_if: output channel, one eroded cell per beat
// valid/ready handshake; a beat moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface tce_result_if
  import tce_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               wall;
  logic [COORD_W-1:0] out_line;
  logic [COORD_W-1:0] out_pos;
  logic               last_of_run;

  modport source (output valid, output wall, output out_line, output out_pos,
                  output last_of_run, input ready);
  modport sink   (input valid, input wall, input out_line, input out_pos,
                  input last_of_run, output ready);
endinterface : tce_result_if
`default_nettype wire

>>> design/tce_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tce_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module tce_ram #(
  parameter  int WIDTH = 2,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tce_ram
`default_nettype wire

>>> design/threshold_cross_erosion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_cross_erosion: thresholded random map with 3x3 cross erosion
// Samples arrive in scan order; each becomes a raw wall bit, and the eroded
// result of the line above is emitted one beat per cell; the last line is also emitted, all wall.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+---------------------------------------
//  samples   | in  | valid / ready    | random_sample, map_start
//  cells     | out | valid / ready    | wall, out_line, out_pos, last_of_run
//  cfg       | in  | cfg_write        | cfg_index, cfg_data
//
//  One sample per clock sustained while the queue has room; each beat passes
//  through the RAM read stage, then its results enter an 8-entry result queue.
//  Both raw lines share one 2-bit wide RAM (older, newer) of MAX_LINE_LENGTH
//  entries; one read and one write per cycle set the rate.
//  Cells on the last line give two results, so on that line the queue fills
//  and samples.ready drops at times even while cells.ready stays high.
//  Reset clears counters and queue and resets config; the RAM is not cleared.
//  A stall on cells fills the queue, then drops samples.ready.
//
module threshold_cross_erosion
  import tce_pkg::*;
#(
  parameter int MAX_LINE_LENGTH = 1024,
  parameter int MAX_LINE_COUNT  = 1024,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  tce_sample_if.sink                  samples,
  tce_result_if.source                cells,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW   = $clog2(MAX_LINE_LENGTH);
  localparam int LW   = $clog2(MAX_LINE_COUNT);
  localparam int CMPW = (SAMPLE_BITS > THRESHOLD_W) ? SAMPLE_BITS : THRESHOLD_W;

  // configuration
  logic [THRESHOLD_W-1:0] wall_threshold;
  logic [LEN_CFG_W-1:0]   line_length;
  logic [LEN_CFG_W-1:0]   line_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_threshold <= THRESHOLD_RESET;
      line_length    <= LENGTH_RESET;
      line_count     <= COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_WALL_THRESHOLD: wall_threshold <= cfg_data[THRESHOLD_W-1:0];
        REG_LINE_LENGTH:    line_length    <= cfg_data[LEN_CFG_W-1:0];
        REG_LINE_COUNT:     line_count     <= cfg_data[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // last position and last line, from lengths clamped to [3, MAX]
  logic [PW-1:0] len_m1;
  logic [LW-1:0] cnt_m1;

  always_comb begin
    if (line_length < LEN_MIN) begin
      len_m1 = PW'(2);
    end else if (32'(line_length) > 32'(MAX_LINE_LENGTH)) begin
      len_m1 = PW'(MAX_LINE_LENGTH - 1);
    end else begin
      len_m1 = PW'(line_length - LEN_CFG_W'(1));
    end
    if (line_count < LEN_MIN) begin
      cnt_m1 = LW'(2);
    end else if (32'(line_count) > 32'(MAX_LINE_COUNT)) begin
      cnt_m1 = LW'(MAX_LINE_COUNT - 1);
    end else begin
      cnt_m1 = LW'(line_count - LEN_CFG_W'(1));
    end
  end

  // ---------------------------------------------------------------- accept
  logic [PW-1:0]        pos_counter;
  logic [LW-1:0]        line_counter;
  logic                 acc;
  logic [PW-1:0]        ps0;
  logic [LW-1:0]        ln0;
  logic                 last_pos0;
  logic                 last_line0;
  logic                 raw0;
  logic [PW-1:0]        pos_next;
  logic [LW-1:0]        line_next;
  logic [PW-1:0]        rd_addr;
  logic [RES_CNT_W-1:0] res_count;
  logic                 s1_valid;

  assign samples.ready = (res_count + RES_CNT_W'({s1_valid, 1'b0}))
                         <= RES_CNT_W'(RES_DEPTH - 2);
  assign acc = samples.valid && samples.ready;

  always_comb begin
    ps0        = samples.map_start ? '0 : pos_counter;
    ln0        = samples.map_start ? '0 : line_counter;
    last_pos0  = ps0 >= len_m1;
    last_line0 = ln0 >= cnt_m1;
    raw0       = CMPW'(samples.random_sample) >= CMPW'(wall_threshold);
    if (last_pos0) begin
      pos_next  = '0;
      line_next = last_line0 ? '0 : ln0 + LW'(1);
    end else begin
      pos_next  = ps0 + PW'(1);
      line_next = ln0;
    end
    // fetch the entry of the next cell: the right neighbor of this one, or position 0 after the last
    rd_addr = (32'(pos_next) > 32'(MAX_LINE_LENGTH - 1)) ?
              PW'(MAX_LINE_LENGTH - 1) : pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_counter  <= '0;
      line_counter <= '0;
    end else if (acc) begin
      pos_counter  <= pos_next;
      line_counter <= line_next;
    end
  end

  // ------------------------------------------------------------ read stage
  logic [PW-1:0] s1_ps;
  logic [LW-1:0] s1_ln;
  logic          s1_raw;
  logic          s1_last_pos;
  logic          s1_last_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
    if (acc) begin
      s1_ps        <= ps0;
      s1_ln        <= ln0;
      s1_raw       <= raw0;
      s1_last_pos  <= last_pos0;
      s1_last_line <= last_line0;
    end
  end

  // entry bit 1: older line, bit 0: newer line
  logic [1:0]    rd_data;
  logic [1:0]    cur;       // entry at s1_ps, fetched by the previous beat
  logic          left;      // line L-1 at s1_ps - 1
  logic [PW-1:0] wr_addr;

  assign wr_addr = (32'(s1_ps) > 32'(MAX_LINE_LENGTH - 1)) ?
                   PW'(MAX_LINE_LENGTH - 1) : s1_ps;

  tce_ram #(
    .WIDTH (2),
    .DEPTH (MAX_LINE_LENGTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (wr_addr),
    .wdata ({cur[0], s1_raw}),
    .re    (acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      cur  <= rd_data;
      left <= cur[0];
    end
  end

  logic    border;
  logic    eroded;
  logic    emit;
  logic    emit2;
  result_t res0;
  result_t res1;

  always_comb begin
    border = (s1_ln == LW'(1)) || (s1_ps == '0) || s1_last_pos;
    eroded = border | (s1_raw & left & rd_data[0] & cur[1] & cur[0]);
    emit   = s1_valid && (s1_ln != '0);
    emit2  = emit && s1_last_line;
    res0.wall        = eroded;
    res0.out_line    = COORD_W'(s1_ln - LW'(1));
    res0.out_pos     = COORD_W'(s1_ps);
    res0.last_of_run = !s1_last_line;
    res1.wall        = 1'b1;
    res1.out_line    = COORD_W'(s1_ln);
    res1.out_pos     = COORD_W'(s1_ps);
    res1.last_of_run = 1'b1;
  end

  // ---------------------------------------------------------- result queue
  result_t              res_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wptr;
  logic [RES_PTR_W-1:0] rptr;
  logic                 pop;
  logic [1:0]           push_n;

  assign pop    = cells.valid && cells.ready;
  assign push_n = {1'b0, emit} + {1'b0, emit2};

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      res_count <= '0;
    end else begin
      wptr      <= wptr + RES_PTR_W'(push_n);
      rptr      <= rptr + RES_PTR_W'(pop);
      res_count <= res_count + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
    end
    if (emit) begin
      res_mem[wptr] <= res0;
    end
    if (emit2) begin
      res_mem[wptr + RES_PTR_W'(1)] <= res1;
    end
  end

  assign cells.valid       = res_count != '0;
  assign cells.wall        = res_mem[rptr].wall;
  assign cells.out_line    = res_mem[rptr].out_line;
  assign cells.out_pos     = res_mem[rptr].out_pos;
  assign cells.last_of_run = res_mem[rptr].last_of_run;

  // ------------------------------------------------------------ assertions
  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_accept_to_read : assert property (@(posedge clk) disable iff (rst)
    acc |=> s1_valid)
    else $error("accepted beat missing from read stage");

  a_pair_together : assert property (@(posedge clk) disable iff (rst)
    (cells.valid && !cells.last_of_run) |-> (res_count >= RES_CNT_W'(2)))
    else $error("first result of a pair queued without its second");

  a_ready_room : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && samples.ready) |-> (res_count <= RES_CNT_W'(RES_DEPTH - 4)))
    else $error("beat taken without room for its results");

endmodule : threshold_cross_erosion
`default_nettype wire

>>> bench/tb_threshold_cross_erosion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_cross_erosion: self-checking bench for the cross erosion block
// Streams random maps in scan order through the sample channel. A scoreboard
// model predicts every eroded cell beat, and the monitor checks each beat
// field by field. Both channels idle and stall at random, with two long
// receiver hold-offs so that the result queue fills and stalls the input.
// ----------------------------------------------------------------------------
module tb_threshold_cross_erosion;
  import tce_pkg::*;

  localparam int LEN_CAP     = 1024;
  localparam int QUIET_LIMIT = 3000;   // cycles with no beat on either channel
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 16;

  typedef struct {
    logic [15:0] sample;
    logic        start;
  } sample_beat_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tce_sample_if #(.SAMPLE_BITS(16)) smp ();
  tce_result_if                     cel ();

  threshold_cross_erosion #(
    .MAX_LINE_LENGTH(1024),
    .MAX_LINE_COUNT (1024),
    .SAMPLE_BITS    (16)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (smp),
    .cells    (cel),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scoreboard model state
  logic [15:0]  thr_reg;
  logic [10:0]  len_reg;
  logic [10:0]  cnt_reg;
  bit           older_row [LEN_CAP];
  bit           newer_row [LEN_CAP];
  int           row_ctr;
  int           col_ctr;

  sample_beat_t pending_samples [$];
  result_t      expected_cells  [$];

  int mismatches;
  int samples_taken;
  int cells_seen;
  int settings_used;
  int random_items;
  int quiet_cycles;
  int burst_left;
  int gap_left;
  int hold_left;
  int stall_tick;

  function automatic int clamp_size(input logic [10:0] raw);
    if (raw < 11'd3) return 3;
    if (raw > 11'(LEN_CAP)) return LEN_CAP;
    return int'(raw);
  endfunction

  // Advance the map model by one sample beat and queue the cells it emits.
  task automatic erode_cell(input logic [15:0] sample, input logic start);
    int      eff_len;
    int      eff_cnt;
    int      row;
    int      col;
    bit      raw;
    bit      end_col;
    bit      end_row;
    result_t cell_out;
    eff_len = clamp_size(len_reg);
    eff_cnt = clamp_size(cnt_reg);
    if (start) begin
      row_ctr = 0;
      col_ctr = 0;
    end
    row     = row_ctr;
    col     = col_ctr;
    raw     = (sample >= thr_reg);
    end_col = (col >= eff_len - 1);
    end_row = (row >= eff_cnt - 1);
    if (row >= 1) begin
      cell_out.out_line    = 10'(row - 1);
      cell_out.out_pos     = 10'(col);
      cell_out.last_of_run = !end_row;
      if (row == 1 || col == 0 || end_col) begin
        cell_out.wall = 1'b1;
      end else begin
        // the left cell of the line above has already moved to the older row
        cell_out.wall = raw & older_row[col-1] & newer_row[col+1] &
                        older_row[col] & newer_row[col];
      end
      expected_cells.push_back(cell_out);
      if (end_row) begin
        cell_out.wall        = 1'b1;
        cell_out.out_line    = 10'(row);
        cell_out.last_of_run = 1'b1;
        expected_cells.push_back(cell_out);
      end
    end
    older_row[col] = newer_row[col];
    newer_row[col] = raw;
    if (end_col) begin
      col_ctr = 0;
      row_ctr = end_row ? 0 : row + 1;
    end else begin
      col_ctr = col + 1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_cell();
    result_t want;
    cells_seen++;
    if (expected_cells.size() == 0) begin
      report_mismatch($sformatf("unexpected beat line %0d pos %0d",
                                cel.out_line, cel.out_pos));
      return;
    end
    want = expected_cells.pop_front();
    if (cel.wall !== want.wall)
      report_mismatch($sformatf("wall %b, want %b at line %0d pos %0d",
                                cel.wall, want.wall, want.out_line, want.out_pos));
    if (cel.out_line !== want.out_line)
      report_mismatch($sformatf("out_line %0d, want %0d", cel.out_line, want.out_line));
    if (cel.out_pos !== want.out_pos)
      report_mismatch($sformatf("out_pos %0d, want %0d at line %0d",
                                cel.out_pos, want.out_pos, want.out_line));
    if (cel.last_of_run !== want.last_of_run)
      report_mismatch($sformatf("last_of_run %b, want %b at line %0d pos %0d",
                                cel.last_of_run, want.last_of_run,
                                want.out_line, want.out_pos));
  endtask

  // Sample driver: bursts of random length with random gaps.
  always @(posedge clk) begin
    sample_beat_t beat_in;
    if (rst) begin
      smp.valid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!smp.valid || smp.ready) begin
      if (smp.valid) begin
        erode_cell(smp.random_sample, smp.map_start);
        samples_taken++;
      end
      if (gap_left > 0 || pending_samples.size() == 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        smp.valid <= 1'b0;
      end else begin
        beat_in = pending_samples.pop_front();
        smp.valid         <= 1'b1;
        smp.random_sample <= beat_in.sample;
        smp.map_start     <= beat_in.start;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Cell monitor: checks each beat, stalls on a rotating pattern.
  always @(posedge clk) begin
    if (rst) begin
      cel.ready  <= 1'b0;
      hold_left  = 0;
      stall_tick = 0;
    end else begin
      if (cel.valid && cel.ready) begin
        check_cell();
        if (cells_seen == 120 || cells_seen == 300) hold_left = HOLD_CYCLES;
      end
      stall_tick++;
      if (hold_left > 0) begin
        hold_left--;
        cel.ready <= 1'b0;
      end else begin
        case ((stall_tick / 50) % 4)
          0:       cel.ready <= 1'b1;
          1:       cel.ready <= 1'($urandom_range(0, 1));
          2:       cel.ready <= ($urandom_range(0, 3) != 0);
          default: cel.ready <= ((stall_tick % 7) < 4);
        endcase
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (cel.valid && cel.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(input cfg_reg_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WALL_THRESHOLD: thr_reg = value;
      REG_LINE_LENGTH:    len_reg = value[10:0];
      REG_LINE_COUNT:     cnt_reg = value[10:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] thr, input logic [10:0] len_raw,
                           input logic [10:0] cnt_raw);
    write_register(REG_WALL_THRESHOLD, thr);
    write_register(REG_LINE_LENGTH, 16'(len_raw));
    write_register(REG_LINE_COUNT, 16'(cnt_raw));
    settings_used++;
    @(negedge clk);
  endtask

  // Wait until every beat is out, then give the block time to go quiet.
  task automatic settle();
    while (pending_samples.size() != 0 || smp.valid || expected_cells.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample(input logic [15:0] thr);
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return thr - 16'd1;
      4, 5:    return thr;
      6:       return thr + 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_sample(input logic [15:0] sample, input logic start);
    sample_beat_t b;
    b.sample = sample;
    b.start  = start;
    pending_samples.push_back(b);
  endtask

  task automatic queue_lines(input int n_lines, input int len, input logic [15:0] thr,
                             input bit start);
    for (int l = 0; l < n_lines; l++)
      for (int p = 0; p < len; p++)
        queue_sample(pick_sample(thr), start && l == 0 && p == 0);
  endtask

  task automatic run_random_phase();
    logic [15:0] thr;
    logic [10:0] len_raw;
    logic [10:0] cnt_raw;
    int          len;
    int          cnt;
    int          maps;
    int          lines;
    bit          need_start;
    case ($urandom_range(0, 5))
      0:       thr = 16'h0000;
      1:       thr = 16'hFFFF;
      2, 3:    thr = THRESHOLD_RESET;
      default: thr = 16'($urandom);
    endcase
    len_raw = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2))
                                          : 11'($urandom_range(3, 9));
    cnt_raw = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2))
                                          : 11'($urandom_range(3, 9));
    configure(thr, len_raw, cnt_raw);
    len        = clamp_size(len_raw);
    cnt        = clamp_size(cnt_raw);
    maps       = $urandom_range(1, 3);
    need_start = 1'b1;
    for (int m = 0; m < maps; m++) begin
      // now and then abandon a map early and restart at a line boundary
      lines = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cnt - 1) : cnt;
      queue_lines(lines, len, thr, need_start || $urandom_range(0, 1) == 1);
      need_start = (lines < cnt);
      random_items += lines * len;
    end
    settle();
  endtask

  initial begin
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = REG_WALL_THRESHOLD;
    cfg_data          = '0;
    smp.valid         = 1'b0;
    smp.random_sample = '0;
    smp.map_start     = 1'b0;
    cel.ready         = 1'b0;
    thr_reg           = THRESHOLD_RESET;
    len_reg           = LENGTH_RESET;
    cnt_reg           = COUNT_RESET;
    row_ctr           = 0;
    col_ctr           = 0;
    mismatches        = 0;
    samples_taken     = 0;
    cells_seen        = 0;
    settings_used     = 0;
    random_items      = 0;
    quiet_cycles      = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Top threshold, undersized length and count that clamp to 3x3; the
    // second map follows by wrap-around with no map_start.
    configure(16'hFFFF, 11'd2, 11'd0);
    queue_sample(16'h0000, 1'b1);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'hFFFE, 1'b0);
    repeat (3) queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'h0001, 1'b0);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'h8000, 1'b0);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'hFFFE, 1'b0);
    repeat (7) queue_sample(16'hFFFF, 1'b0);
    settle();

    // Shrink length and count mid-map: the position and the line counter
    // both land beyond the new last index and must wrap.
    configure(THRESHOLD_RESET, 11'd4, 11'd5);
    queue_lines(3, 4, THRESHOLD_RESET, 1'b1);
    for (int p = 0; p < 3; p++) queue_sample(pick_sample(THRESHOLD_RESET), 1'b0);
    settle();
    write_register(REG_LINE_LENGTH, 16'd3);
    write_register(REG_LINE_COUNT, 16'd3);
    @(negedge clk);
    queue_sample(THRESHOLD_RESET, 1'b0);
    settle();

    while (random_items < 400) run_random_phase();

    $display("run: %0d sample beats, %0d cell beats checked over %0d register settings",
             samples_taken, cells_seen, settings_used);
    $display("run: thresholds 0 to 65535, lines of 3 to 9 cells, maps of 3 to 9 lines");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : tb_threshold_cross_erosion
